// ----- rtl/minimal_standard_lcg_ranged_macros.svh -----
// assertion macros used by the lcg controller
`ifndef MINIMAL_STANDARD_LCG_RANGED_MACROS_SVH
`define MINIMAL_STANDARD_LCG_RANGED_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcg assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcg assertion failed");

`endif

// ----- rtl/mslcg_pkg.sv -----
// shared constants and control types of the bounded minimal standard lcg
`default_nettype none
package mslcg_pkg;

  localparam int unsigned STATE_W = 31;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = STATE_W + MULT_W;
  localparam int unsigned BOUND_W = 32;

  localparam logic [MULT_W-1:0]  LCG_MULT  = 15'd16807;
  localparam logic [STATE_W-1:0] LCG_MOD   = 31'h7fffffff;
  localparam logic [STATE_W-1:0] SEED_MASK = 31'd123459876;

  // request kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  // one remainder step per state bit
  localparam int unsigned DIV_STEPS = STATE_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // controller to datapath
  typedef struct packed {
    logic seed_load;
    logic bound_load;
    logic mul;
    logic reduce;
    logic div_step;
    logic res_load;
    logic res_zero;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bound_pos;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/minimal_standard_lcg_ranged.sv -----
// Bounded Park-Miller minimal standard generator (multiplier 16807, modulus
// 2^31-1). A draw request with a positive bound advances the 31-bit state and
// returns state mod bound; a bound of zero or less returns 0 without touching
// the state; a reseed request loads the state and returns nothing. One
// request is in work at a time. A reseed loads the state at acceptance. A
// draw with a non-positive bound goes from acceptance to the deliver state,
// where its zero is loaded into the output register once the output is free.
// A draw with a positive bound steps from acceptance through a multiply
// step, a fold step, the bit-serial remainder unit with one step per state
// bit and an output load step in the deliver state; the next request is
// taken only after the result is loaded.
// The output register holds a finished result while a new request is taken;
// a stalled output delays the load of the next result and, with it, the
// next accept.
`default_nettype none
module minimal_standard_lcg_ranged (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic signed [mslcg_pkg::BOUND_W-1:0] range_max_i,
  input  logic [mslcg_pkg::STATE_W-1:0] seed_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mslcg_pkg::STATE_W-1:0] random_value_o
);
  import mslcg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  mslcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic
  mslcg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .range_max_i    (range_max_i),
    .seed_value_i   (seed_value_i),
    .random_value_o (random_value_o)
  );

endmodule
`default_nettype wire

// ----- rtl/mslcg_datapath.sv -----
// generator state, modular multiply, fold and restoring remainder unit
`default_nettype none
module mslcg_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mslcg_pkg::cmd_t               cmd_i,
  output mslcg_pkg::status_t            status_o,
  input  logic signed [mslcg_pkg::BOUND_W-1:0] range_max_i,
  input  logic [mslcg_pkg::STATE_W-1:0] seed_value_i,
  output logic [mslcg_pkg::STATE_W-1:0] random_value_o
);
  import mslcg_pkg::*;

  logic [STATE_W-1:0] state_q, state_d;
  logic [STATE_W-1:0] bound_q;
  logic [PROD_W-1:0]  prod_q;
  logic [STATE_W-1:0] rem_q, rem_d;
  logic [STATE_W-1:0] dvd_q;
  logic [STATE_W-1:0] result_q;
  logic [STATE_W-1:0] seed_eff;
  logic [STATE_W:0]   fold_sum;
  logic [STATE_W:0]   fold_sub;
  logic [STATE_W-1:0] fold;
  logic [STATE_W:0]   rem_sh;
  logic [STATE_W+1:0] rem_diff;

  // bound is usable only when positive
  assign status_o.bound_pos = !range_max_i[BOUND_W-1] && (|range_max_i[BOUND_W-2:0]);

  // reseed value, with the mask value itself mapped to zero first
  assign seed_eff = (seed_value_i == SEED_MASK) ? '0 : seed_value_i;

  // fold the 46-bit product modulo 2^31-1
  assign fold_sum = {{(STATE_W + 1 - MULT_W){1'b0}}, prod_q[PROD_W-1:STATE_W]}
                  + {1'b0, prod_q[STATE_W-1:0]};
  assign fold_sub = fold_sum - {1'b0, LCG_MOD};
  assign fold     = (fold_sum >= {1'b0, LCG_MOD}) ? fold_sub[STATE_W-1:0]
                                                  : fold_sum[STATE_W-1:0];

  // next generator state
  always_comb begin
    state_d = state_q;
    if (cmd_i.seed_load) begin
      state_d = seed_eff ^ SEED_MASK;
    end else if (cmd_i.reduce) begin
      state_d = fold;
    end
  end

  // one restoring remainder step
  assign rem_sh   = {rem_q, dvd_q[STATE_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, bound_q};
  assign rem_d    = rem_diff[STATE_W+1] ? rem_sh[STATE_W-1:0] : rem_diff[STATE_W-1:0];

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEED_MASK;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.bound_load) begin
      bound_q <= range_max_i[STATE_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(state_q) * PROD_W'(LCG_MULT);
    end
    if (cmd_i.reduce) begin
      dvd_q <= fold;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[STATE_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.res_load) begin
      result_q <= cmd_i.res_zero ? '0 : rem_q;
    end
  end

  assign random_value_o = result_q;

endmodule
`default_nettype wire

// ----- rtl/mslcg_ctrl.sv -----
// request sequencing, remainder step count and output valid
`default_nettype none
`include "minimal_standard_lcg_ranged_macros.svh"
module mslcg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mslcg_pkg::status_t status_i,
  output mslcg_pkg::cmd_t    cmd_o
);
  import mslcg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_REDUCE,
    ST_DIVIDE,
    ST_DELIVER
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              zero_q, zero_d;
  logic              out_valid_q, out_valid_d;
  logic              in_acc;
  logic              out_free;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // commands to the datapath
  always_comb begin
    cmd_o            = '0;
    cmd_o.bound_load = in_acc;
    cmd_o.seed_load  = in_acc && (kind_i == KIND_RESEED);
    cmd_o.mul        = (state_q == ST_MULT);
    cmd_o.reduce     = (state_q == ST_REDUCE);
    cmd_o.div_step   = (state_q == ST_DIVIDE);
    cmd_o.res_load   = (state_q == ST_DELIVER) && out_free;
    cmd_o.res_zero   = zero_q;
  end

  // next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_i == KIND_DRAW)) begin
          if (status_i.bound_pos) begin
            zero_d  = 1'b0;
            state_d = ST_MULT;
          end else begin
            zero_d  = 1'b1;
            state_d = ST_DELIVER;
          end
        end
      end
      ST_MULT: begin
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        cnt_d   = '0;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // checks
  `LCG_ASSERT_NXT(a_draw_starts_mult,
                  in_acc && (kind_i == KIND_DRAW) && status_i.bound_pos,
                  state_q == ST_MULT)
  `LCG_ASSERT_NXT(a_last_step_delivers,
                  (state_q == ST_DIVIDE) && (cnt_q == CNT_LAST),
                  state_q == ST_DELIVER)
  `LCG_ASSERT_NXT(a_deliver_sets_valid,
                  (state_q == ST_DELIVER) && !out_valid_q,
                  out_valid_q && (state_q == ST_IDLE))
  `LCG_ASSERT_IMP(a_valid_from_deliver,
                  $rose(out_valid_q),
                  $past(state_q) == ST_DELIVER)

endmodule
`default_nettype wire
